// File: hdl/pef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pef_pkg
// Shared constants, register map and types for the Prewitt edge filter.
// ----------------------------------------------------------------------------
package pef_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WIDTH_W    = COL_W + 1;
	localparam int HEIGHT_W   = 12;
	localparam int PIX_W      = 8;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
	localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_EN_H   = 2'd2,
		REG_EN_V   = 2'd3
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_t;

	// line memory word: previous row in low byte, row before it in high byte
	typedef struct packed {
		pix_t older;
		pix_t prev;
	} line_word_t;

endpackage

// File: hdl/prewitt_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prewitt_edge_filter
// 3x3 Prewitt gradient filter on a raster stream of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high and returns one magnitude
// per interior pixel once the pixel that completes its window has passed the
// registered read of the line memory (both previous rows share one 16-bit
// word) and then the gradient adders into the output register. Border
// pixels produce no output, so a frame of H x W pixels yields (H-2) x (W-2)
// results; m_tlast marks the end of each output row and m_tuser the end of
// the frame. Line memory and window start undefined and only feed an output
// after being filled by the first two rows and columns. Change configuration
// only between frames while the stream is idle.
module prewitt_edge_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pef_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pef_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pef_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	// pixel input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] pixel
	// magnitude output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // [7:0] magnitude
	output logic                            m_tlast,  // row_last
	output logic                            m_tuser   // [0] frame_last
);

	// ------------------------------------------------------------ registers
	logic [pef_pkg::WIDTH_W-1:0]  width_q;
	logic [pef_pkg::HEIGHT_W-1:0] height_q;
	logic                         en_h_q;
	logic                         en_v_q;

	logic                         cfg_wr;
	pef_pkg::reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = pef_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pef_pkg::WIDTH_RESET;
			height_q <= pef_pkg::HEIGHT_RESET;
			en_h_q   <= 1'b1;
			en_v_q   <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pef_pkg::REG_WIDTH:  width_q  <= pwdata[pef_pkg::WIDTH_W-1:0];
				pef_pkg::REG_HEIGHT: height_q <= pwdata[pef_pkg::HEIGHT_W-1:0];
				pef_pkg::REG_EN_H:   en_h_q   <= pwdata[0];
				pef_pkg::REG_EN_V:   en_v_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pef_pkg::REG_WIDTH:  prdata = pef_pkg::APB_DATA_W'(width_q);
			pef_pkg::REG_HEIGHT: prdata = pef_pkg::APB_DATA_W'(height_q);
			pef_pkg::REG_EN_H:   prdata = pef_pkg::APB_DATA_W'(en_h_q);
			pef_pkg::REG_EN_V:   prdata = pef_pkg::APB_DATA_W'(en_v_q);
			default:             prdata = '0;
		endcase
	end

	// ------------------------------------------------------- frame geometry
	logic [pef_pkg::WIDTH_W-1:0]  width_eff;
	logic [pef_pkg::HEIGHT_W-1:0] height_eff;
	pef_pkg::col_t                col_last;
	logic [pef_pkg::HEIGHT_W-1:0] row_last_idx;

	always_comb begin
		if (width_q < pef_pkg::WIDTH_MIN)
			width_eff = pef_pkg::WIDTH_MIN;
		else if (width_q > pef_pkg::WIDTH_MAX)
			width_eff = pef_pkg::WIDTH_MAX;
		else
			width_eff = width_q;
		height_eff = (height_q < pef_pkg::HEIGHT_MIN) ? pef_pkg::HEIGHT_MIN : height_q;
	end

	assign col_last     = pef_pkg::COL_W'(width_eff - pef_pkg::WIDTH_W'(1));
	assign row_last_idx = height_eff - pef_pkg::HEIGHT_W'(1);

	// ------------------------------------------------------------- handshake
	logic in_fire;
	logic adv1;
	logic s1_fire;
	logic s1_valid_s1;
	logic out_valid_q;

	assign adv1     = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_s1 || adv1;
	assign in_fire  = s_tvalid && s_tready;
	assign s1_fire  = s1_valid_s1 && adv1;

	// -------------------------------------------------------- position count
	pef_pkg::col_t                col_q;
	logic [pef_pkg::HEIGHT_W-1:0] row_q;
	logic                         at_col_end;
	logic                         at_row_end;

	assign at_col_end = col_q >= col_last;
	assign at_row_end = row_q >= row_last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (at_col_end) begin
				col_q <= '0;
				row_q <= at_row_end ? '0 : row_q + pef_pkg::HEIGHT_W'(1);
			end else begin
				col_q <= col_q + pef_pkg::COL_W'(1);
			end
		end
	end

	// ---------------------------------------------------------- line memory
	pef_pkg::line_word_t line_mem_q [pef_pkg::MAX_WIDTH];
	pef_pkg::line_word_t rd_s1;
	pef_pkg::col_t       addr_s1;
	pef_pkg::pix_t       pix_s1;
	logic                emit_s1;
	logic                rlast_s1;
	logic                flast_s1;

	always_ff @(posedge clk) begin
		if (in_fire)
			rd_s1 <= line_mem_q[col_q];
		if (s1_fire)
			line_mem_q[addr_s1] <= '{older: rd_s1.prev, prev: pix_s1};
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1  <= col_q;
			pix_s1   <= s_tdata;
			emit_s1  <= (row_q >= pef_pkg::HEIGHT_W'(2)) && (col_q >= pef_pkg::COL_W'(2));
			rlast_s1 <= at_col_end;
			flast_s1 <= at_col_end && at_row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (s_tready)
			s1_valid_s1 <= s_tvalid;
	end

	// ------------------------------------------------------ window, gradient
	// wc1 / wc2: the two most recent columns, index 0 = top row
	pef_pkg::pix_t wc1_q [3];
	pef_pkg::pix_t wc2_q [3];

	logic [9:0]  left_sum, right_sum, top_sum, bot_sum;
	logic [10:0] gx, gy;
	logic [9:0]  gx_pos, gy_pos;
	logic [10:0] mag_sum;
	logic [7:0]  mag;

	always_comb begin
		left_sum  = 10'(wc1_q[0]) + 10'(wc1_q[1]) + 10'(wc1_q[2]);
		right_sum = 10'(rd_s1.older) + 10'(rd_s1.prev) + 10'(pix_s1);
		top_sum   = 10'(wc1_q[0]) + 10'(wc2_q[0]) + 10'(rd_s1.older);
		bot_sum   = 10'(wc1_q[2]) + 10'(wc2_q[2]) + 10'(pix_s1);
		gx        = {1'b0, left_sum} - {1'b0, right_sum};
		gy        = {1'b0, top_sum} - {1'b0, bot_sum};
		gx_pos    = (en_h_q && !gx[10]) ? gx[9:0] : '0;
		gy_pos    = (en_v_q && !gy[10]) ? gy[9:0] : '0;
		mag_sum   = {1'b0, gx_pos} + {1'b0, gy_pos};
		mag       = (mag_sum > 11'd255) ? 8'hFF : mag_sum[7:0];
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			wc1_q    <= wc2_q;
			wc2_q[0] <= rd_s1.older;
			wc2_q[1] <= rd_s1.prev;
			wc2_q[2] <= pix_s1;
		end
	end

	// -------------------------------------------------------- output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv1)
			out_valid_q <= s1_valid_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			m_tdata <= mag;
			m_tlast <= rlast_s1;
			m_tuser <= flast_s1;
		end
	end

	assign m_tvalid = out_valid_q;

	// ------------------------------------------------------------ assertions
	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without row end");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled with room in pipeline");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !adv1 |=> s1_valid_s1 && $stable(pix_s1) && $stable(addr_s1))
		else $error("stage 1 changed while stalled");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && $stable(width_q) && !at_col_end |=> col_q <= col_last)
		else $error("column counter past row end");

endmodule
